[src/alarm_event_annunciator_macros.svh]
// Assertion macros shared by the annunciator RTL.
`ifndef ALARM_EVENT_ANNUNCIATOR_MACROS_SVH
`define ALARM_EVENT_ANNUNCIATOR_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define AEA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define AEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/aea_pkg.sv]
// Shared types and constants for the alarm event annunciator.
`default_nettype none
package aea_pkg;

  localparam int TIME_BITS = 32;
  localparam int NSLOT     = 7;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int IN_W      = 48;
  localparam int OUT_W     = 8;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_ALERT_MASK   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_ESC_BEEP_EN  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_STARTUP_DLY  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GROUND_DBNC  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LEAK_REPEAT  = 3'd4;

  // Tone codes
  localparam logic [3:0] TONE_NONE        = 4'd0;
  localparam logic [3:0] TONE_STARTUP     = 4'd1;
  localparam logic [3:0] TONE_ARM         = 4'd2;
  localparam logic [3:0] TONE_DISARM      = 4'd3;
  localparam logic [3:0] TONE_LINK_OK     = 4'd4;
  localparam logic [3:0] TONE_LINK_LOST   = 4'd5;
  localparam logic [3:0] TONE_GROUND_LOST = 4'd6;
  localparam logic [3:0] TONE_LEAK        = 4'd7;
  localparam logic [3:0] TONE_CAL_START   = 4'd8;
  localparam logic [3:0] TONE_CAL_DONE    = 4'd9;

  // Alert mask bits
  localparam int MB_STARTUP = 0;
  localparam int MB_ARM     = 1;
  localparam int MB_DISARM  = 2;
  localparam int MB_LINK    = 3;
  localparam int MB_GROUND  = 4;
  localparam int MB_LEAK    = 5;
  localparam int MB_CAL     = 6;

  typedef struct packed {
    logic [6:0]  alert_mask;
    logic        esc_beep_enable;
    logic [15:0] startup_delay_ms;
    logic [15:0] ground_loss_debounce_ms;
    logic [15:0] leak_repeat_ms;
  } cfg_t;

  // One tick's worth of results, slot order is emission order.
  typedef struct packed {
    logic [NSLOT-1:0]       valid;
    logic [NSLOT-1:0]       esc;
    logic [NSLOT-1:0][3:0]  tone;
  } entry_t;

endpackage
`default_nettype wire

[src/aea_front.sv]
// Tick front end: tracks flag history and timers, builds the result list.
`default_nettype none
module aea_front import aea_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cfg_t            cfg,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  input  wire logic            q_full,
  output logic                 q_push,
  output entry_t               q_wdata
);

  logic [TIME_BITS-1:0] now;
  logic armed, link, leak, cal, ground;
  logic [3:0] req;
  logic accept;

  logic started, armed_prev, link_prev, link_seen, ground_seen;
  logic ground_counting, ground_loss_reported, leak_prev, cal_prev;
  logic [TIME_BITS-1:0] ground_loss_start, leak_last_alert;

  logic [TIME_BITS-1:0] ground_elapsed, leak_elapsed;
  logic startup_ev, arm_ev, link_ev, ground_ev, leak_ev, cal_ev;

  assign now    = TIME_BITS'(s_tdata[31:0]);
  assign armed  = s_tdata[32];
  assign link   = s_tdata[33];
  assign leak   = s_tdata[34];
  assign cal    = s_tdata[35];
  assign ground = s_tdata[36];
  assign req    = s_tdata[40:37];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign ground_elapsed = now - ground_loss_start;
  assign leak_elapsed   = now - leak_last_alert;

  assign startup_ev = !started && (now > TIME_BITS'(cfg.startup_delay_ms));
  assign arm_ev     = armed != armed_prev;
  assign link_ev    = (link != link_prev) && link_seen;
  assign ground_ev  = !ground && ground_seen && ground_counting && !ground_loss_reported
                      && (ground_elapsed > TIME_BITS'(cfg.ground_loss_debounce_ms));
  assign leak_ev    = leak && (!leak_prev
                      || (leak_elapsed > TIME_BITS'(cfg.leak_repeat_ms)));
  assign cal_ev     = cal != cal_prev;

  always_comb begin
    q_wdata = '0;
    // startup: a masked tone still goes out when it carries the beep
    q_wdata.tone[0]  = cfg.alert_mask[MB_STARTUP] ? TONE_STARTUP : TONE_NONE;
    q_wdata.esc[0]   = cfg.esc_beep_enable;
    q_wdata.valid[0] = startup_ev && (cfg.alert_mask[MB_STARTUP] || cfg.esc_beep_enable);
    if (armed) begin
      q_wdata.tone[1]  = cfg.alert_mask[MB_ARM] ? TONE_ARM : TONE_NONE;
      q_wdata.esc[1]   = cfg.esc_beep_enable;
      q_wdata.valid[1] = arm_ev && (cfg.alert_mask[MB_ARM] || cfg.esc_beep_enable);
    end else begin
      q_wdata.tone[1]  = TONE_DISARM;
      q_wdata.valid[1] = arm_ev && cfg.alert_mask[MB_DISARM];
    end
    q_wdata.tone[2]  = link ? TONE_LINK_OK : TONE_LINK_LOST;
    q_wdata.valid[2] = link_ev && cfg.alert_mask[MB_LINK];
    q_wdata.tone[3]  = TONE_GROUND_LOST;
    q_wdata.valid[3] = ground_ev && cfg.alert_mask[MB_GROUND];
    q_wdata.tone[4]  = TONE_LEAK;
    q_wdata.valid[4] = leak_ev && cfg.alert_mask[MB_LEAK];
    q_wdata.tone[5]  = cal ? TONE_CAL_START : TONE_CAL_DONE;
    q_wdata.valid[5] = cal_ev && cfg.alert_mask[MB_CAL];
    q_wdata.tone[6]  = req;
    q_wdata.valid[6] = (req != TONE_NONE) && cfg.alert_mask[MB_CAL];
  end

  // Ticks with no result update state only.
  assign q_push = accept && (|q_wdata.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      started              <= 1'b0;
      armed_prev           <= 1'b0;
      link_prev            <= 1'b0;
      link_seen            <= 1'b0;
      ground_seen          <= 1'b0;
      ground_counting      <= 1'b0;
      ground_loss_reported <= 1'b0;
      ground_loss_start    <= '0;
      leak_prev            <= 1'b0;
      leak_last_alert      <= '0;
      cal_prev             <= 1'b0;
    end else if (accept) begin
      if (startup_ev) started <= 1'b1;
      armed_prev <= armed;
      link_prev  <= link;
      if (link) link_seen <= 1'b1;
      if (ground) begin
        ground_seen          <= 1'b1;
        ground_counting      <= 1'b0;
        ground_loss_start    <= '0;
        ground_loss_reported <= 1'b0;
      end else if (ground_seen) begin
        if (!ground_counting) begin
          ground_counting   <= 1'b1;
          ground_loss_start <= now;
        end else if (ground_ev) begin
          ground_loss_reported <= 1'b1;
        end
      end
      if (leak_ev) leak_last_alert <= now;
      leak_prev <= leak;
      cal_prev  <= cal;
    end
  end

endmodule
`default_nettype wire

[src/aea_queue.sv]
// Short FIFO of per-tick result lists between front and back end.
`default_nettype none
module aea_queue import aea_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t wdata,
  output logic        full,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        empty
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/aea_back.sv]
// Back end: unrolls one result list into output words, one per cycle unless the output stalls.
`default_nettype none
module aea_back import aea_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire entry_t      q_rdata,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  entry_t           cur;
  logic [NSLOT-1:0] pick, remain;
  logic             out_load, adv, cur_free;
  logic [3:0]       sel_tone;
  logic             sel_esc;

  assign out_load = !m_tvalid || m_tready;
  assign adv      = out_load && (|cur.valid);
  // lowest pending slot goes next
  assign pick     = cur.valid & ~(cur.valid - 1'b1);
  assign remain   = cur.valid & ~pick;
  assign cur_free = !(|cur.valid) || (adv && !(|remain));
  assign q_pop    = cur_free && !q_empty;

  always_comb begin
    sel_tone = '0;
    sel_esc  = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      sel_tone = sel_tone | (cur.tone[i] & {4{pick[i]}});
      sel_esc  = sel_esc | (cur.esc[i] & pick[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur.valid <= q_rdata.valid;
      end else if (adv) begin
        cur.valid <= remain;
      end
      if (out_load) m_tvalid <= |cur.valid;
    end
    if (q_pop) begin
      cur.tone <= q_rdata.tone;
      cur.esc  <= q_rdata.esc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, sel_esc, sel_tone};
      m_tlast <= !(|remain);
    end
  end

endmodule
`default_nettype wire

[src/alarm_event_annunciator.sv]
// Top level of the alarm event annunciator: config registers, front, queue, back.
//
//  Channel   Dir  Signals                         Contents
//  ticks     in   s_tvalid s_tready s_tdata[47:0] one status sample per word
//  alerts    out  m_tvalid m_tready m_tdata[7:0]  one tone per word, m_tlast ends tick
//  config    in   cfg_we cfg_addr cfg_data        register writes, no read-back
//
// A tick is taken whenever the queue has room, so ticks can arrive back
// to back. A tick with n results gives n output words (n up to 7, ticks
// with none produce no word); the output port, one word per cycle while
// m_tready is high, sets the sustained rate. The four-entry queue lets the
// front keep taking ticks while the back drains. A tick's first word passes
// the queue, the current-list register and the output register. Reset is
// synchronous and clears all flag history, timers and config to defaults.
`default_nettype none
module alarm_event_annunciator import aea_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // tick words
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // [31:0] time_ms, [32] armed, [33] link_up, [34] leak_active,
  // [35] calibrating, [36] ground_link_up, [40:37] requested_tone, [47:41] zero
  input  wire logic [IN_W-1:0]   s_tdata,
  // alert words
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // [3:0] tone, [4] esc_beep, [7:5] zero
  output logic [OUT_W-1:0]       m_tdata,
  output logic                   m_tlast,
  // config writes
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_data
);

`include "alarm_event_annunciator_macros.svh"

  cfg_t   cfg;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  // Config registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alert_mask              <= 7'd127;
      cfg.esc_beep_enable         <= 1'b0;
      cfg.startup_delay_ms        <= 16'd900;
      cfg.ground_loss_debounce_ms <= 16'd1500;
      cfg.leak_repeat_ms          <= 16'd3000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ALERT_MASK:  cfg.alert_mask              <= cfg_data[6:0];
        REG_ESC_BEEP_EN: cfg.esc_beep_enable         <= cfg_data[0];
        REG_STARTUP_DLY: cfg.startup_delay_ms        <= cfg_data;
        REG_GROUND_DBNC: cfg.ground_loss_debounce_ms <= cfg_data;
        REG_LEAK_REPEAT: cfg.leak_repeat_ms          <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Front: classify each tick and build its ordered result list.
  aea_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Queue: decouple tick intake from word output.
  aea_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Back: emit pending results in slot order through a registered output.
  aea_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Never push into a full queue, never pop an empty one.
  `AEA_ASSERT_IMP(a_push_room, q_push, !q_full, "push into full queue")
  `AEA_ASSERT_IMP(a_pop_data, q_pop, !q_empty, "pop from empty queue")
  // Every emitted word carries a tone or a beep.
  `AEA_ASSERT_IMP(a_word_nonempty, m_tvalid, (m_tdata[3:0] != TONE_NONE) || m_tdata[4],
                  "empty alert word emitted")
  // A word taken without tlast must be followed by another of the same tick.
  `AEA_ASSERT_NEXT(a_tick_continues, m_tvalid && m_tready && !m_tlast, m_tvalid,
                   "tick result list broken off")

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the alarm event annunciator: directed and random ticks, scored per word.
module testbench;
  import aea_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  // Cycles to let pass once nothing is due: covers the tick-to-word latency.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] time_ms;
    logic        armed;
    logic        link_up;
    logic        leak_active;
    logic        calibrating;
    logic        ground_link_up;
    logic [3:0]  requested_tone;
  } tick_t;

  typedef struct packed {
    logic [3:0] tone;
    logic       esc_beep;
    logic       last;
  } alert_t;

  // Tracks flag history and timers, and holds the alert words still due.
  class tone_tracker;
    logic [6:0]  alert_mask;
    logic        esc_beep_en;
    logic [15:0] startup_dly;
    logic [15:0] ground_dbnc;
    logic [15:0] leak_rep;

    bit          started, armed_prev, link_prev, link_seen;
    bit          ground_seen, ground_counting, ground_reported;
    bit          leak_prev, cal_prev;
    logic [31:0] ground_start;
    logic [31:0] leak_last;

    alert_t      due_alerts[$];
    int          errors, words, ticks, writes;

    function new();
      alert_mask  = 7'd127;
      esc_beep_en = 1'b0;
      startup_dly = 16'd900;
      ground_dbnc = 16'd1500;
      leak_rep    = 16'd3000;
      ground_start = '0;
      leak_last    = '0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      writes++;
      case (idx)
        REG_ALERT_MASK:  alert_mask  = val[6:0];
        REG_ESC_BEEP_EN: esc_beep_en = val[0];
        REG_STARTUP_DLY: startup_dly = val;
        REG_GROUND_DBNC: ground_dbnc = val;
        REG_LEAK_REPEAT: leak_rep    = val;
        default: ;
      endcase
    endfunction

    function logic [3:0] gated(int pos, logic [3:0] tone);
      return alert_mask[pos] ? tone : TONE_NONE;
    endfunction

    // Drop silent results; a masked tone with a beep still makes a word.
    function void add(logic [3:0] tone, logic esc);
      alert_t a;
      if (tone == TONE_NONE && !esc) return;
      a = '{tone: tone, esc_beep: esc, last: 1'b0};
      due_alerts.push_back(a);
    endfunction

    function void note_tick(tick_t t);
      alert_t      a;
      int          first;
      logic [31:0] now;
      now   = t.time_ms;
      first = due_alerts.size();
      ticks++;

      if (!started && now > {16'd0, startup_dly}) begin
        started = 1'b1;
        add(gated(MB_STARTUP, TONE_STARTUP), esc_beep_en);
      end

      if (t.armed != armed_prev) begin
        if (t.armed) add(gated(MB_ARM, TONE_ARM), esc_beep_en);
        else add(gated(MB_DISARM, TONE_DISARM), 1'b0);
        armed_prev = t.armed;
      end

      // The first link up only arms the link alerts.
      if (t.link_up != link_prev) begin
        if (t.link_up) begin
          if (link_seen) add(gated(MB_LINK, TONE_LINK_OK), 1'b0);
          link_seen = 1'b1;
        end else if (link_seen) begin
          add(gated(MB_LINK, TONE_LINK_LOST), 1'b0);
        end
        link_prev = t.link_up;
      end

      if (t.ground_link_up) begin
        ground_seen     = 1'b1;
        ground_counting = 1'b0;
        ground_start    = '0;
        ground_reported = 1'b0;
      end else if (ground_seen) begin
        if (!ground_counting) begin
          ground_counting = 1'b1;
          ground_start    = now;
        end else if (!ground_reported && (now - ground_start) > {16'd0, ground_dbnc}) begin
          ground_reported = 1'b1;
          add(gated(MB_GROUND, TONE_GROUND_LOST), 1'b0);
        end
      end

      if (t.leak_active && (!leak_prev || (now - leak_last) > {16'd0, leak_rep})) begin
        add(gated(MB_LEAK, TONE_LEAK), 1'b0);
        leak_last = now;
      end
      leak_prev = t.leak_active;

      if (t.calibrating != cal_prev) begin
        add(gated(MB_CAL, t.calibrating ? TONE_CAL_START : TONE_CAL_DONE), 1'b0);
        cal_prev = t.calibrating;
      end

      // The requested tone shares the calibration enable.
      if (t.requested_tone != 4'd0) add(gated(MB_CAL, t.requested_tone), 1'b0);

      if (due_alerts.size() > first) begin
        a = due_alerts.pop_back();
        a.last = 1'b1;
        due_alerts.push_back(a);
      end
    endfunction

    function void check_alert(logic [OUT_W-1:0] data, logic last_flag);
      alert_t want;
      words++;
      if (due_alerts.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: mismatch, expected no word, got tone %0d esc %0b last %0b",
                   $time, data[3:0], data[4], last_flag);
        return;
      end
      want = due_alerts.pop_front();
      if (data[3:0] !== want.tone || data[4] !== want.esc_beep || last_flag !== want.last) begin
        errors++;
        if (errors <= 40)
          $display("%0t: mismatch, expected tone %0d esc %0b last %0b, got %0d %0b %0b",
                   $time, want.tone, want.esc_beep, want.last, data[3:0], data[4],
                   last_flag);
      end
    endfunction

    function void check_drained();
      if (due_alerts.size() != 0) begin
        errors++;
        $display("%0t: mismatch, expected %0d more words (next tone %0d esc %0b), got none",
                 $time, due_alerts.size(), due_alerts[0].tone, due_alerts[0].esc_beep);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  tone_tracker tracker = new();
  tick_t       cur_tick = '0;
  bit          idle_on = 1'b1;
  bit          long_hold_go = 1'b0;
  int          cycle_count = 0;

  alarm_event_annunciator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d words still due", $time, tracker.due_alerts.size());
      $display("[alarm_event_annunciator] ERROR");
      $finish;
    end
  end

  // Score every accepted alert word against the oldest one due.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_alert(m_tdata, m_tlast);
  end

  // Alert side backpressure: random bursts of stall, or one long hold on request.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_go) begin
        long_hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic tick_t mk(logic [31:0] ms, logic arm, logic lnk, logic lk,
                               logic cal, logic gnd, logic [3:0] rq);
    return '{time_ms: ms, armed: arm, link_up: lnk, leak_active: lk,
             calibrating: cal, ground_link_up: gnd, requested_tone: rq};
  endfunction

  // Advance time mostly in small steps so debounce and repeat timers get hit;
  // flip flags now and then, with an occasional fully random tick as noise.
  function automatic tick_t next_tick(tick_t prev);
    tick_t t;
    int    pick;
    t    = prev;
    pick = $urandom_range(0, 9);
    if (pick >= 1 && pick <= 6) t.time_ms = prev.time_ms + $urandom_range(1, 1200);
    else if (pick >= 7 && pick <= 8) t.time_ms = prev.time_ms + $urandom_range(1, 80000);
    else if (pick == 9) t.time_ms = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      {t.armed, t.link_up, t.leak_active, t.calibrating, t.ground_link_up} = 5'($urandom());
    end else begin
      if ($urandom_range(0, 5) == 0) t.armed = ~t.armed;
      if ($urandom_range(0, 5) == 0) t.link_up = ~t.link_up;
      if ($urandom_range(0, 5) == 0) t.leak_active = ~t.leak_active;
      if ($urandom_range(0, 5) == 0) t.calibrating = ~t.calibrating;
      if ($urandom_range(0, 5) == 0) t.ground_link_up = ~t.ground_link_up;
    end
    t.requested_tone = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    return t;
  endfunction

  // Offer one tick word, after an optional gap, and hold it until taken.
  task automatic issue(tick_t t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - 41){1'b0}}, t.requested_tone, t.ground_link_up, t.calibrating,
                 t.leak_active, t.link_up, t.armed, t.time_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_tick(t);
    cur_tick = t;
  endtask

  // Stop offering ticks and let every due word out, then settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.due_alerts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_config(logic [6:0] mask, logic esc, logic [15:0] startup,
                              logic [15:0] dbnc, logic [15:0] leak_rep);
    write_reg(REG_ALERT_MASK, {9'd0, mask});
    write_reg(REG_ESC_BEEP_EN, {15'd0, esc});
    write_reg(REG_STARTUP_DLY, startup);
    write_reg(REG_GROUND_DBNC, dbnc);
    write_reg(REG_LEAK_REPEAT, leak_rep);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int settings;
    settings = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Startup masked but beeping, slowest startup and debounce, no leak repeat gap.
    apply_config(7'h7E, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    settings++;
    issue(mk(32'd0,       1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // nothing happens
    issue(mk(32'd100,     1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0));  // first link and ground up
    issue(mk(32'd200,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // link lost, ground timer starts
    issue(mk(32'd65535,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // startup delay not exceeded
    // Every alert in one tick, startup word carries only the beep.
    issue(mk(32'h20000,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd12));
    issue(mk(32'h20000,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0));  // leak held, no time passed
    issue(mk(32'h20001,   1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0));  // leak re-alert
    issue(mk(32'h20002,   1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 4'd15));
    issue(mk(32'h20003,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd1));
    issue(mk(32'hFFFFFFF0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0)); // ground back, timer cleared
    issue(mk(32'hFFFFFFF8, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    issue(mk(32'hFFFFFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    issue(mk(32'd0,       1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd9));  // time wraps under the leak
    wait_idle();

    // All alerts masked: only the arm beep gets through, the request is swallowed.
    apply_config(7'h00, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
    settings++;
    issue(mk(32'h100,   1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd5));
    issue(mk(32'h101,   1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd10));
    issue(mk(32'h102,   1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    issue(mk(32'h10102, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    wait_idle();

    // Defaults: walk the debounce and repeat thresholds one ms at a time.
    apply_config(7'h7F, 1'b0, 16'd900, 16'd1500, 16'd3000);
    settings++;
    issue(mk(32'h20000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0));
    issue(mk(32'h20010, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0));
    issue(mk(32'h205EC, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0));
    issue(mk(32'h205ED, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    issue(mk(32'h211A5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    issue(mk(32'h211A6, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    wait_idle();

    // Random part, one register setting per phase; the last phase runs without idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: apply_config(7'h7F, 1'b0, 16'd900, 16'd1500, 16'd3000);
        1: apply_config(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                        16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                        16'($urandom_range(0, 3000)));
        2: apply_config(7'h2A, 1'b1, 16'd50, 16'd800, 16'd400);
        default: apply_config(7'h7F, 1'b1, 16'd0, 16'd2000, 16'd600);
      endcase
      settings++;
      idle_on = (ph < 3);
      for (int n = 0; n < 45; n++) begin
        if (ph == 0 && n == 5) long_hold_go = 1'b1;  // fill the queue behind a stalled sink
        if (ph == 0 && n == 25) wait_idle();    // sender pause until all words are out
        issue(next_tick(cur_tick));
      end
      wait_idle();
    end

    tracker.check_drained();
    $display("Ran %0d ticks under %0d register settings (%0d writes), scored %0d alert words.",
             tracker.ticks, settings, tracker.writes, tracker.words);
    $display("Mismatches: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("[alarm_event_annunciator] OK");
    end else begin
      $display("[alarm_event_annunciator] ERROR");
    end
    $finish;
  end

endmodule
